/* sv/rv32d_pkg.sv */
// rv32i decoder package: instruction codes, decode result record and funct3 code tables
// no dependencies

package rv32d_pkg;

   typedef enum logic [5:0] {
      CODE_ILLEGAL = 6'd0,
      CODE_LUI, CODE_AUIPC, CODE_JAL, CODE_JALR,
      CODE_BEQ, CODE_BNE, CODE_BLT, CODE_BGE, CODE_BLTU, CODE_BGEU,
      CODE_LB, CODE_LH, CODE_LW, CODE_LBU, CODE_LHU,
      CODE_SB, CODE_SH, CODE_SW,
      CODE_ADDI, CODE_SLTI, CODE_SLTIU, CODE_XORI, CODE_ORI, CODE_ANDI,
      CODE_SLLI, CODE_SRLI, CODE_SRAI,
      CODE_ADD, CODE_SUB, CODE_SLL, CODE_SLT, CODE_SLTU, CODE_XOR, CODE_SRL, CODE_SRA,
      CODE_OR, CODE_AND,
      CODE_ECALL, CODE_EBREAK,
      CODE_CSRRW, CODE_CSRRS, CODE_CSRRC, CODE_CSRRWI, CODE_CSRRSI, CODE_CSRRCI
   } code_type;

   typedef struct packed {
      code_type           code;
      logic [4:0]         rd;
      logic [4:0]         rs1;
      logic [4:0]         rs2;
      logic signed [31:0] imm;
      logic [31:0]        target;
      logic [11:0]        csr;
   } dec_result_type;

   function automatic code_type branch_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd0:    c = CODE_BEQ;
         3'd1:    c = CODE_BNE;
         3'd4:    c = CODE_BLT;
         3'd5:    c = CODE_BGE;
         3'd6:    c = CODE_BLTU;
         3'd7:    c = CODE_BGEU;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

   function automatic code_type load_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd0:    c = CODE_LB;
         3'd1:    c = CODE_LH;
         3'd2:    c = CODE_LW;
         3'd4:    c = CODE_LBU;
         3'd5:    c = CODE_LHU;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

   function automatic code_type store_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd0:    c = CODE_SB;
         3'd1:    c = CODE_SH;
         3'd2:    c = CODE_SW;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

   function automatic code_type alui_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd0:    c = CODE_ADDI;
         3'd2:    c = CODE_SLTI;
         3'd3:    c = CODE_SLTIU;
         3'd4:    c = CODE_XORI;
         3'd6:    c = CODE_ORI;
         3'd7:    c = CODE_ANDI;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

   function automatic code_type alu_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd0:    c = CODE_ADD;
         3'd1:    c = CODE_SLL;
         3'd2:    c = CODE_SLT;
         3'd3:    c = CODE_SLTU;
         3'd4:    c = CODE_XOR;
         3'd5:    c = CODE_SRL;
         3'd6:    c = CODE_OR;
         3'd7:    c = CODE_AND;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

   function automatic code_type csr_code(input logic [2:0] f3);
      code_type c;
      unique case (f3)
         3'd1:    c = CODE_CSRRW;
         3'd2:    c = CODE_CSRRS;
         3'd3:    c = CODE_CSRRC;
         3'd5:    c = CODE_CSRRWI;
         3'd6:    c = CODE_CSRRSI;
         3'd7:    c = CODE_CSRRCI;
         default: c = CODE_ILLEGAL;
      endcase
      return c;
   endfunction

endpackage

/* sv/rv32d_decode.sv */
// combinational rv32i decode: code, register fields, immediate, csr number, pc-relative target
// depends on rv32d_pkg

module rv32d_decode (
   input  logic [31:0]             instr_address,
   input  logic [31:0]             instruction_word,
   output rv32d_pkg::dec_result_type result
);
   import rv32d_pkg::*;

   typedef enum logic [3:0] {
      FMT_NONE, FMT_U, FMT_J, FMT_I, FMT_S, FMT_B, FMT_R, FMT_SH, FMT_CSR
   } fmt_type;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_ALUI   = 7'h13;
   localparam logic [6:0] OP_ALU    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   logic [31:0] w;
   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   code_type    code;
   fmt_type     fmt;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
   logic [31:0] pc_sum;

   assign w  = instruction_word;
   assign op = w[6:0];
   assign f3 = w[14:12];
   assign f7 = w[31:25];

   assign imm_i = {{20{w[31]}}, w[31:20]};
   assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
   assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   assign imm_u = {w[31:12], 12'h000};

   always_comb begin
      code = CODE_ILLEGAL;
      fmt  = FMT_NONE;
      unique case (op)
         OP_LUI: begin
            code = CODE_LUI;
            fmt  = FMT_U;
         end
         OP_AUIPC: begin
            code = CODE_AUIPC;
            fmt  = FMT_U;
         end
         OP_JAL: begin
            code = CODE_JAL;
            fmt  = FMT_J;
         end
         OP_JALR: begin
            if (f3 == 3'd0) begin
               code = CODE_JALR;
               fmt  = FMT_I;
            end
         end
         OP_BRANCH: begin
            code = branch_code(f3);
            fmt  = FMT_B;
         end
         OP_LOAD: begin
            code = load_code(f3);
            fmt  = FMT_I;
         end
         OP_STORE: begin
            code = store_code(f3);
            fmt  = FMT_S;
         end
         OP_ALUI: begin
            priority if (f3 == 3'd1) begin
               if (f7 == F7_ZERO) begin
                  code = CODE_SLLI;
                  fmt  = FMT_SH;
               end
            end else if (f3 == 3'd5) begin
               priority if (f7 == F7_ZERO) begin
                  code = CODE_SRLI;
                  fmt  = FMT_SH;
               end else if (f7 == F7_ALT) begin
                  code = CODE_SRAI;
                  fmt  = FMT_SH;
               end else begin
                  code = CODE_ILLEGAL;
               end
            end else begin
               code = alui_code(f3);
               fmt  = FMT_I;
            end
         end
         OP_ALU: begin
            priority if (f7 == F7_ZERO) begin
               code = alu_code(f3);
               fmt  = FMT_R;
            end else if (f7 == F7_ALT && f3 == 3'd0) begin
               code = CODE_SUB;
               fmt  = FMT_R;
            end else if (f7 == F7_ALT && f3 == 3'd5) begin
               code = CODE_SRA;
               fmt  = FMT_R;
            end else begin
               code = CODE_ILLEGAL;
            end
         end
         OP_SYSTEM: begin
            priority if (w == WORD_ECALL) begin
               code = CODE_ECALL;
            end else if (w == WORD_EBREAK) begin
               code = CODE_EBREAK;
            end else begin
               code = csr_code(f3);
               fmt  = FMT_CSR;
            end
         end
         default: begin
            code = CODE_ILLEGAL;
         end
      endcase
   end

   // one adder shared by jal and branches
   assign pc_sum = instr_address + ((fmt == FMT_J) ? imm_j : imm_b);

   always_comb begin
      result        = '0;
      result.code   = code;
      if (code != CODE_ILLEGAL) begin
         unique case (fmt)
            FMT_U: begin
               result.rd  = w[11:7];
               result.imm = imm_u;
            end
            FMT_J: begin
               result.rd     = w[11:7];
               result.imm    = imm_j;
               result.target = pc_sum;
            end
            FMT_I: begin
               result.rd  = w[11:7];
               result.rs1 = w[19:15];
               result.imm = imm_i;
            end
            FMT_SH: begin
               result.rd  = w[11:7];
               result.rs1 = w[19:15];
               result.imm = {27'd0, w[24:20]};
            end
            FMT_S: begin
               result.rs1 = w[19:15];
               result.rs2 = w[24:20];
               result.imm = imm_s;
            end
            FMT_B: begin
               result.rs1    = w[19:15];
               result.rs2    = w[24:20];
               result.imm    = imm_b;
               result.target = pc_sum;
            end
            FMT_R: begin
               result.rd  = w[11:7];
               result.rs1 = w[19:15];
               result.rs2 = w[24:20];
            end
            FMT_CSR: begin
               result.rd  = w[11:7];
               result.rs1 = w[19:15];
               result.csr = w[31:20];
            end
            default: begin
               result.rd = 5'd0;
            end
         endcase
      end
   end

endmodule

/* sv/rv32i_instruction_decoder.sv */
// rv32i instruction decoder top level: input register, decode logic, result register
// rsp_valid rises once the req has passed through the input register and the result register;
// throughput one instruction per cycle, set by the single decode pass between
// the two pipeline registers, stalls only on rsp_ready
// synchronous active-high reset empties both registers; no other state
// depends on rv32d_pkg and rv32d_decode

module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_address,
   input  logic [31:0]        req_instruction_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_mnemonic_code,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic signed [31:0] rsp_immediate,
   output logic [31:0]        rsp_target_address,
   output logic [11:0]        rsp_csr_number
);
   import rv32d_pkg::*;

   logic           in_valid_ff;
   logic [31:0]    in_addr_ff;
   logic [31:0]    in_word_ff;
   logic           out_valid_ff;
   dec_result_type out_ff;
   dec_result_type dec_in;
   logic           adv_out;
   logic           adv_in;

   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_in    = !in_valid_ff || adv_out;
   assign req_ready = adv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv_in) begin
         in_valid_ff <= req_valid;
      end
      if (adv_in && req_valid) begin
         in_addr_ff <= req_instr_address;
         in_word_ff <= req_instruction_word;
      end
   end

   rv32d_decode u_decode (
      .instr_address    (in_addr_ff),
      .instruction_word (in_word_ff),
      .result           (dec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv_out) begin
         out_valid_ff <= in_valid_ff;
      end
      if (adv_out && in_valid_ff) begin
         out_ff <= dec_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mnemonic_code  = out_ff.code;
   assign rsp_dest_reg       = out_ff.rd;
   assign rsp_src1_reg       = out_ff.rs1;
   assign rsp_src2_reg       = out_ff.rs2;
   assign rsp_immediate      = out_ff.imm;
   assign rsp_target_address = out_ff.target;
   assign rsp_csr_number     = out_ff.csr;

`ifndef SYNTH
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.code == CODE_ILLEGAL |->
         out_ff.rd == 5'd0 && out_ff.rs1 == 5'd0 && out_ff.rs2 == 5'd0 &&
         out_ff.imm == 32'sd0 && out_ff.target == 32'd0 && out_ff.csr == 12'd0)
      else $error("illegal instruction with nonzero fields");

   a_target_only_jumps: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.target != 32'd0 |->
         out_ff.code == CODE_JAL || out_ff.code == CODE_BEQ || out_ff.code == CODE_BNE ||
         out_ff.code == CODE_BLT || out_ff.code == CODE_BGE || out_ff.code == CODE_BLTU ||
         out_ff.code == CODE_BGEU)
      else $error("target set for a non-jump instruction");

   a_csr_only_csr: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.csr != 12'd0 |->
         out_ff.code == CODE_CSRRW || out_ff.code == CODE_CSRRS ||
         out_ff.code == CODE_CSRRC || out_ff.code == CODE_CSRRWI ||
         out_ff.code == CODE_CSRRSI || out_ff.code == CODE_CSRRCI)
      else $error("csr number set for a non-csr instruction");

   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && adv_out |=> out_valid_ff)
      else $error("decoded instruction lost between stages");
`endif

endmodule
